>>> rtl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the positional list buffer.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CNT_RAW_W = $clog2(DEPTH + 1);
  // common width for positions, cell indexes and the element count
  localparam int unsigned CW = (CNT_RAW_W > POS_W) ? CNT_RAW_W : POS_W;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INS,
    CMD_DEL,
    CMD_MOD,
    CMD_READ
  } plb_cmd_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } plb_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [LEN_W-1:0]         length;
  } plb_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    plb_cmd_e          cmd;
    logic [CW-1:0]     pos;
    logic [DATA_W-1:0] value;
  } plb_ctl_t;

endpackage

>>> rtl/positional_list_buffer_top.sv
// ----------------------------------------------------------------------------
// positional_list_buffer_top
// Ordered list of signed words with read, insert, delete and modify by
// position, built as a chain of slot cells under a small controller.
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid_i/in_ready_o | in_data_i  (plb_in_t)
//   out     | out | out_valid_o/out_ready_i | out_data_o (plb_out_t)
//
// Insert, delete, modify and any refused operation: the result is registered
// at the accepting edge. A successful read passes through S_RD and S_DONE:
// the word travels one cell a cycle down the read chain to slot 0.
// Reset clears the count and control only; slot contents are undefined.
// A new word is taken once the controller is idle and the output register
// is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module positional_list_buffer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  plb_pkg::plb_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output plb_pkg::plb_out_t  out_data_o
);
  import plb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_d, state_q;
  logic [CW-1:0] count_d, count_q;
  logic [CW-1:0] pos_d, pos_q;
  logic [CW-1:0] rd_cnt_d, rd_cnt_q;
  logic          out_valid_d, out_valid_q;
  plb_out_t      out_d, out_q;

  logic          in_fire;
  logic [CW-1:0] pos_w;
  logic [1:0]    st;
  logic          is_full, is_empty;
  plb_ctl_t      ctl;

  logic [DATA_W-1:0] data_w [DEPTH];
  logic [DATA_W-1:0] rd_w   [DEPTH];

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign pos_w      = CW'(in_data_i.position);
  assign is_full    = (count_q == CW'(DEPTH));
  assign is_empty   = (count_q == '0);

  always_comb begin
    if (in_data_i.opcode == OP_INSERT) begin
      if (is_full) begin
        st = ST_FULL;
      end else if (is_empty || (pos_w <= count_q)) begin
        st = ST_OK;
      end else begin
        st = ST_BADPOS;
      end
    end else if (is_empty) begin
      st = ST_EMPTY;
    end else if (pos_w >= count_q) begin
      st = ST_BADPOS;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    ctl.cmd   = CMD_NONE;
    ctl.pos   = is_empty ? '0 : pos_w;
    ctl.value = in_data_i.value;
    if (state_q != S_IDLE) begin
      ctl.cmd = CMD_READ;
      ctl.pos = pos_q;
    end else if (in_fire && (st == ST_OK)) begin
      unique case (in_data_i.opcode)
        OP_READ:   ctl.cmd = CMD_READ;
        OP_INSERT: ctl.cmd = CMD_INS;
        OP_DELETE: ctl.cmd = CMD_DEL;
        OP_MODIFY: ctl.cmd = CMD_MOD;
        default:   ctl.cmd = CMD_NONE;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    rd_cnt_d    = rd_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_data_i.opcode == OP_READ) && (st == ST_OK)) begin
            state_d  = S_RD;
            pos_d    = pos_w;
            rd_cnt_d = pos_w;
          end else begin
            if (st == ST_OK) begin
              if (in_data_i.opcode == OP_INSERT) begin
                count_d = count_q + CW'(1);
              end else if (in_data_i.opcode == OP_DELETE) begin
                count_d = count_q - CW'(1);
              end
            end
            out_valid_d      = 1'b1;
            out_d.read_value = '0;
            out_d.status     = st;
            out_d.length     = count_d[LEN_W-1:0];
          end
        end
      end
      S_RD: begin
        if (rd_cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          rd_cnt_d = rd_cnt_q - CW'(1);
        end
      end
      S_DONE: begin
        state_d          = S_IDLE;
        out_valid_d      = 1'b1;
        out_d.read_value = rd_w[0];
        out_d.status     = ST_OK;
        out_d.length     = count_q[LEN_W-1:0];
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    out_q <= out_d;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] lower, upper, rd_in;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = '0;
      assign rd_in = '0;
    end else begin : g_mid_hi
      assign upper = data_w[g+1];
      assign rd_in = rd_w[g+1];
    end
    plb_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (CW'(g)),
      .lower_i (lower),
      .upper_i (upper),
      .rd_i    (rd_in),
      .data_o  (data_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above depth");

  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.opcode != OP_READ) |=> out_valid_q)
    else $error("non-read word gave no result");

  a_rd_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> !out_valid_q && !in_ready_o)
    else $error("output busy or input open during read walk");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_full && (in_data_i.opcode == OP_INSERT) |=> $stable(count_q))
    else $error("refused insert changed the count");

endmodule

>>> rtl/plb_cell.sv
// ----------------------------------------------------------------------------
// plb_cell
// One list slot: holds an entry, shifts with its neighbors on insert and
// delete, and passes read words down the chain toward slot 0.
// ----------------------------------------------------------------------------
module plb_cell (
  input  logic                         clk_i,
  input  plb_pkg::plb_ctl_t            ctl_i,
  input  logic [plb_pkg::CW-1:0]       idx_i,
  input  logic [plb_pkg::DATA_W-1:0]   lower_i,
  input  logic [plb_pkg::DATA_W-1:0]   upper_i,
  input  logic [plb_pkg::DATA_W-1:0]   rd_i,
  output logic [plb_pkg::DATA_W-1:0]   data_o,
  output logic [plb_pkg::DATA_W-1:0]   rd_o
);
  import plb_pkg::*;

  logic [DATA_W-1:0] data_d, data_q;
  logic [DATA_W-1:0] rd_d, rd_q;
  logic              hit, above;

  assign hit   = (idx_i == ctl_i.pos);
  assign above = (idx_i > ctl_i.pos);

  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      CMD_INS: begin
        if (hit) begin
          data_d = ctl_i.value;
        end else if (above) begin
          data_d = lower_i;
        end
      end
      CMD_DEL: begin
        if (hit || above) begin
          data_d = upper_i;
        end
      end
      CMD_MOD: begin
        if (hit) begin
          data_d = ctl_i.value;
        end
      end
      default: data_d = data_q;
    endcase
  end

  assign rd_d = ((ctl_i.cmd == CMD_READ) && hit) ? data_q : rd_i;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule
